FILE: hdl/grid_min_path_sum_assert.svh
// Assertion macros shared by the grid minimum path sum RTL.
`ifndef GRID_MIN_PATH_SUM_ASSERT_SVH
`define GRID_MIN_PATH_SUM_ASSERT_SVH

// same-cycle implication
`define GMPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GMPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/gmps_pkg.sv
// Package: constants and register codes of the grid minimum path sum block.
`default_nettype none
package gmps_pkg;
   localparam int MAX_COLUMNS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT    = 4096;
   localparam int COST_WIDTH_DEFAULT  = 16;

   localparam int CELL_COST_W = 16;
   localparam int PATH_SUM_W  = 32;
   localparam int CFG_COLS_W  = 11;
   localparam int CFG_ROWS_W  = 13;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int COLS_RESET  = 1024;
   localparam int ROWS_RESET  = 4096;

   localparam logic REG_GRID_COLUMNS = 1'b0;
   localparam logic REG_GRID_ROWS    = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/gmps_req_if.sv
// Interface: cell cost channel.
`default_nettype none
interface gmps_req_if;
   logic                            valid;
   logic                            ready;
   logic [gmps_pkg::CELL_COST_W-1:0] cell_cost;

   modport source (output valid, output cell_cost, input ready);
   modport sink   (input valid, input cell_cost, output ready);
endinterface
`default_nettype wire

FILE: hdl/gmps_rsp_if.sv
// Interface: path sum result channel.
`default_nettype none
interface gmps_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gmps_pkg::PATH_SUM_W-1:0] path_sum;
   logic                           grid_done;

   modport source (output valid, output path_sum, output grid_done, input ready);
   modport sink   (input valid, input path_sum, input grid_done, output ready);
endinterface
`default_nettype wire

FILE: hdl/gmps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module gmps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: hdl/grid_min_path_sum.sv
// Top level: streaming least-cost right/down path sums over a grid.
//
// Cell costs enter on req_chan in row-major order, one word per cell; each
// cell gives one word on rsp_chan with its least path sum from the top-left
// cell and grid_done on the bottom-right cell. Sums saturate at all ones.
// Grid size is set through the csr_ port: grid_columns at 0x0 (low 11 bits),
// grid_rows at 0x4 (low 13 bits); zero acts as one, values above the maximum
// act as the maximum. Any write restarts at the top-left cell. Write only while
// no word is in flight. A cost is registered in the compute stage, its sum in
// the output register. Throughput: one cell per cycle unless rsp_chan stalls;
// the previous row is in a line buffer RAM read at acceptance and written from
// the compute stage; a one-column grid gets the just-written sum forwarded.
// Reset clears the position and the output stage; the line buffer is not
// cleared, since every entry is written in a row before it is read.
// When rsp_chan stalls, the output register holds its word, the compute
// stage holds behind it, and req_chan.ready drops once both are full.
`default_nettype none
`include "grid_min_path_sum_assert.svh"
module grid_min_path_sum #(
   parameter int MAX_COLUMNS = gmps_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = gmps_pkg::MAX_ROWS_DEFAULT,
   parameter int COST_WIDTH  = gmps_pkg::COST_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   gmps_req_if.sink                             req_chan,
   gmps_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gmps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [gmps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [gmps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);
   import gmps_pkg::*;

   localparam int COL_W   = MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
   localparam int CCMP_W  = (COL_W > CFG_COLS_W ? COL_W : CFG_COLS_W) + 1;
   localparam int RCMP_W  = (ROW_W > CFG_ROWS_W ? ROW_W : CFG_ROWS_W) + 1;
   localparam int COLS_RST = COLS_RESET > MAX_COLUMNS ? MAX_COLUMNS : COLS_RESET;
   localparam int ROWS_RST = ROWS_RESET > MAX_ROWS ? MAX_ROWS : ROWS_RESET;
   localparam logic [CELL_COST_W-1:0] COST_MASK = (COST_WIDTH >= CELL_COST_W) ? '1 :
      CELL_COST_W'((32'd1 << COST_WIDTH) - 32'd1);

   // configuration
   logic                  cfg_wr;
   logic [CFG_COLS_W-1:0] cols_ff, cols_in, cols_wr;
   logic [CFG_ROWS_W-1:0] rows_ff, rows_in, rows_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cols_wr = csr_pwdata[CFG_COLS_W-1:0];
      if (cols_wr == '0) begin
         cols_wr = CFG_COLS_W'(1);
      end else if (32'(cols_wr) > 32'(MAX_COLUMNS)) begin
         cols_wr = CFG_COLS_W'(MAX_COLUMNS);
      end
      rows_wr = csr_pwdata[CFG_ROWS_W-1:0];
      if (rows_wr == '0) begin
         rows_wr = CFG_ROWS_W'(1);
      end else if (32'(rows_wr) > 32'(MAX_ROWS)) begin
         rows_wr = CFG_ROWS_W'(MAX_ROWS);
      end
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[2])
            REG_GRID_COLUMNS: cols_in = cols_wr;
            REG_GRID_ROWS:    rows_in = rows_wr;
            default:          cols_in = cols_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GRID_COLUMNS: csr_prdata = CSR_DATA_W'(cols_ff);
         REG_GRID_ROWS:    csr_prdata = CSR_DATA_W'(rows_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // position and line buffer read
   logic             req_fire, s1_fire;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             col_last, row_last;

   assign req_fire = req_chan.valid & req_chan.ready;
   assign col_last = (CCMP_W'(col_ff) + CCMP_W'(1)) == CCMP_W'(cols_ff);
   assign row_last = (RCMP_W'(row_ff) + RCMP_W'(1)) == RCMP_W'(rows_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // compute stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]       s1_col_ff;
   logic                   s1_first_row_ff, s1_first_col_ff, s1_done_ff, s1_fwd_ff;
   logic [CELL_COST_W-1:0] s1_cost_ff;
   logic [PATH_SUM_W-1:0]  left_ff, left_in;
   logic [PATH_SUM_W-1:0]  up_rd, up_sum, best, s1_sum;
   logic [PATH_SUM_W:0]    sum_wide;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PATH_SUM_W-1:0]  rsp_sum_ff;
   logic                   rsp_done_ff;

   assign s1_fire        = s1_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | s1_fire;

   gmps_ram #(
      .WIDTH (PATH_SUM_W),
      .DEPTH (MAX_COLUMNS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (s1_sum),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   always_comb begin
      up_sum = s1_fwd_ff ? left_ff : up_rd;
      priority if (s1_first_row_ff) begin
         best = left_ff;
      end else if (s1_first_col_ff) begin
         best = up_sum;
      end else begin
         best = (up_sum < left_ff) ? up_sum : left_ff;
      end
      sum_wide = {1'b0, best} + (PATH_SUM_W + 1)'(s1_cost_ff);
      if (s1_first_row_ff && s1_first_col_ff) begin
         s1_sum = PATH_SUM_W'(s1_cost_ff);
      end else if (sum_wide[PATH_SUM_W]) begin
         s1_sum = '1;
      end else begin
         s1_sum = sum_wide[PATH_SUM_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      left_in = left_ff;
      if (cfg_wr) begin
         left_in = '0;
      end else if (s1_fire) begin
         left_in = s1_sum;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= CFG_COLS_W'(COLS_RST);
         rows_ff      <= CFG_ROWS_W'(ROWS_RST);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff       <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_first_col_ff <= (col_ff == '0);
         s1_done_ff      <= row_last & col_last;
         s1_cost_ff      <= req_chan.cell_cost & COST_MASK;
         s1_fwd_ff       <= s1_fire & (s1_col_ff == col_ff);
      end
      if (s1_fire) begin
         rsp_sum_ff  <= s1_sum;
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.path_sum  = rsp_sum_ff;
   assign rsp_chan.grid_done = rsp_done_ff;

   `GMPS_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_fire, s1_valid_ff,
      "accepted word did not reach the compute stage")
   `GMPS_ASSERT_NOW(a_sum_not_below_cost, clock, reset, s1_fire,
      s1_sum >= PATH_SUM_W'(s1_cost_ff), "path sum below cell cost")
   `GMPS_ASSERT_NEXT(a_wrap_after_last, clock, reset, req_fire && row_last && col_last,
      (col_ff == '0) && (row_ff == '0), "position did not wrap after last cell")
   `GMPS_ASSERT_NEXT(a_hold_when_stalled, clock, reset, rsp_valid_ff && !rsp_chan.ready,
      rsp_valid_ff && $stable(rsp_sum_ff), "stalled result word not held")
endmodule
`default_nettype wire
